// ----- rtl/pus_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle update step: shared package
// Stage counts, register codes, colour constants, the particle word and
// the saturation helper used by the datapath.
// ----------------------------------------------------------------------------
package pus_pkg;

	// pipeline shape
	localparam int DIV_STEPS  = 15;
	localparam int SQRT_STEPS = 16;
	localparam int MOTION_LAT = 4;
	localparam int PIPE_DEPTH = 1 + (DIV_STEPS + 1) + SQRT_STEPS + 1;
	localparam int SIDE_DEPTH = PIPE_DEPTH - 1 - MOTION_LAT;

	// Q1.15 colour constants
	localparam logic [15:0] Q15_ONE = 16'd32768;
	localparam logic [15:0] END_R   = 16'd13107;
	localparam logic [15:0] END_G   = 16'd6554;

	// register map and reset values
	localparam logic        REG_LIFE_EXPL = 1'b0;
	localparam logic        REG_LIFE_EXH  = 1'b1;
	localparam logic [22:0] LIFE_EXPL_RST = 23'd32768;
	localparam logic [22:0] LIFE_EXH_RST  = 23'd16384;

	// particle kind
	localparam logic ACT_EXPLOSION = 1'b0;
	localparam logic ACT_JET       = 1'b1;

	// one particle as it travels down the pipeline
	typedef struct packed {
		logic               action;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] acc_x;
		logic signed [31:0] acc_y;
		logic signed [23:0] ttl;
		logic        [63:0] col;
	} part_t;

	// clamp a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		logic signed [31:0] res;
		if (x > 66'sd2147483647) begin
			res = 32'sh7fffffff;
		end else if (x < -66'sd2147483648) begin
			res = 32'sh80000000;
		end else begin
			res = x[31:0];
		end
		return res;
	endfunction

endpackage

// ----- rtl/particle_update_step_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle update step unit
// Advances one particle by one frame step per cycle unless stalled:
// motion integration, life decrement, life ratio, square root and colour update.
//
//  channel  | handshake          | words
//  ---------+--------------------+-------------------------------------------
//  input    | in_valid/in_stall  | action, dt, cam_vel, pos, vel, acc, ttl, colour
//  output   | out_valid/out_stall| new pos, vel, acc, ttl, colour
//  config   | APB psel/penable   | lifetime_explosion @0, lifetime_exhaust @4
//
// One word accepted per cycle while in_stall is low; from acceptance to
// out_valid a word passes the input stage, 16 divider stages, 16 square-root
// stages, the colour stage and the output register.
// Reset clears the valid bits and loads the lifetime reset values.
// A stalled output word is held in the output register; one more word
// drops into a skid register, after which in_stall rises and the pipe holds.
// ----------------------------------------------------------------------------
module particle_update_step_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic [15:0]        dt,
	input  logic signed [31:0] cam_vel_x,
	input  logic signed [31:0] cam_vel_y,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] acc_x,
	input  logic signed [31:0] acc_y,
	input  logic signed [23:0] ttl,
	input  logic [63:0]        color_rgba,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y,
	output logic signed [31:0] new_acc_x,
	output logic signed [31:0] new_acc_y,
	output logic signed [23:0] new_ttl,
	output logic [63:0]        new_color_rgba
);
	import pus_pkg::*;

	logic [22:0]        life_expl_q;
	logic [22:0]        life_exh_q;
	logic               en;
	logic               vld_q [PIPE_DEPTH];
	part_t              p_s1;
	logic [15:0]        dt_s1;
	logic signed [31:0] cam_x_s1;
	logic signed [31:0] cam_y_s1;
	logic signed [24:0] ttl_dec;
	logic signed [23:0] nttl;
	part_t              p_m;
	part_t              motion_out;
	logic signed [23:0] life;
	logic [22:0]        lifetime;
	logic [15:0]        ratio_d;
	logic [15:0]        root_q15;
	logic [15:0]        ratio_q15;
	logic [63:0]        col_new;
	part_t              side_q [SIDE_DEPTH];
	part_t              last_w;
	part_t              out_q;
	logic               out_vld_q;
	part_t              skid_q;
	logic               skid_vld_q;

	// configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_expl_q <= LIFE_EXPL_RST;
			life_exh_q  <= LIFE_EXH_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_LIFE_EXPL: life_expl_q <= pwdata[22:0];
				REG_LIFE_EXH:  life_exh_q  <= pwdata[22:0];
				default: ;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_LIFE_EXH) ? {9'b0, life_exh_q} : {9'b0, life_expl_q};

	// pipe advances unless the skid register is occupied
	assign en       = !skid_vld_q;
	assign in_stall = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PIPE_DEPTH; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < PIPE_DEPTH; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// stage 1: capture input word
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1.action <= action;
			p_s1.pos_x  <= pos_x;
			p_s1.pos_y  <= pos_y;
			p_s1.vel_x  <= vel_x;
			p_s1.vel_y  <= vel_y;
			p_s1.acc_x  <= acc_x;
			p_s1.acc_y  <= acc_y;
			p_s1.ttl    <= ttl;
			p_s1.col    <= color_rgba;
			dt_s1       <= dt;
			cam_x_s1    <= cam_vel_x;
			cam_y_s1    <= cam_vel_y;
		end
	end

	// decrement time to live, saturating at the bottom
	assign ttl_dec = 25'(p_s1.ttl) - $signed({9'b0, dt_s1});
	assign nttl    = (ttl_dec < -25'sd8388608) ? 24'sh800000 : ttl_dec[23:0];

	always_comb begin
		p_m     = p_s1;
		p_m.ttl = nttl;
	end

	// explosion uses the new life, jet the old
	assign life     = (p_s1.action == ACT_EXPLOSION) ? nttl : p_s1.ttl;
	assign lifetime = (p_s1.action == ACT_EXPLOSION) ? life_expl_q : life_exh_q;

	pus_motion u_motion (
		.clk   (clk),
		.en    (en),
		.dt    (dt_s1),
		.cam_x (cam_x_s1),
		.cam_y (cam_y_s1),
		.p_in  (p_m),
		.p_out (motion_out)
	);

	pus_div u_div (
		.clk      (clk),
		.en       (en),
		.life     (life),
		.lifetime (lifetime),
		.ratio    (ratio_d)
	);

	pus_sqrt u_sqrt (
		.clk       (clk),
		.en        (en),
		.ratio     (ratio_d),
		.root      (root_q15),
		.ratio_out (ratio_q15)
	);

	// carry motion results alongside the ratio path
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= motion_out;
			for (int k = 1; k < SIDE_DEPTH; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	pus_color u_color (
		.clk     (clk),
		.en      (en),
		.action  (side_q[SIDE_DEPTH-2].action),
		.col     (side_q[SIDE_DEPTH-2].col),
		.ratio   (ratio_q15),
		.root    (root_q15),
		.new_col (col_new)
	);

	always_comb begin
		last_w     = side_q[SIDE_DEPTH-1];
		last_w.col = col_new;
	end

	// output register with one-word skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || !out_stall) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= vld_q[PIPE_DEPTH-1];
			end
		end else if (en && vld_q[PIPE_DEPTH-1]) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || !out_stall) begin
			out_q <= skid_vld_q ? skid_q : last_w;
		end else if (en && vld_q[PIPE_DEPTH-1]) begin
			skid_q <= last_w;
		end
	end

	assign out_valid      = out_vld_q;
	assign new_pos_x      = out_q.pos_x;
	assign new_pos_y      = out_q.pos_y;
	assign new_vel_x      = out_q.vel_x;
	assign new_vel_y      = out_q.vel_y;
	assign new_acc_x      = out_q.acc_x;
	assign new_acc_y      = out_q.acc_y;
	assign new_ttl        = out_q.ttl;
	assign new_color_rgba = out_q.col;

	// skid holds a word only behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid word without output word");

	// skid fills only when the output was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_stall) && $past(out_vld_q))
		else $error("skid filled without a stalled output");

	// a word leaving the pipe is never dropped
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_q[PIPE_DEPTH-1] |=> out_vld_q)
		else $error("pipeline word lost");

endmodule

// ----- rtl/pus_motion.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle update step: motion datapath
// Four-stage integration of position, velocity and acceleration.
// ----------------------------------------------------------------------------
module pus_motion (
	input  logic                clk,
	input  logic                en,
	input  logic [15:0]         dt,
	input  logic signed [31:0]  cam_x,
	input  logic signed [31:0]  cam_y,
	input  pus_pkg::part_t      p_in,
	output pus_pkg::part_t      p_out
);
	import pus_pkg::*;

	logic signed [31:0] acc_i [2];
	logic signed [31:0] vel_i [2];
	logic signed [31:0] cam_i [2];
	logic signed [31:0] vel_2 [2];
	logic signed [31:0] pos_3 [2];
	logic signed [31:0] vel_3 [2];
	logic signed [31:0] nacc_w [2];
	logic signed [16:0] dte_i;
	logic signed [16:0] dte_2;

	part_t              p_s2, p_s3, p_s4, p_s5;
	part_t              p5_w;
	logic [15:0]        dt_s2;
	logic signed [48:0] ad_s2   [2];
	logic signed [32:0] diff_s2 [2];
	logic signed [65:0] add_s3  [2];
	logic signed [49:0] bd_s3   [2];
	logic signed [32:0] tvel_s3 [2];
	logic signed [35:0] psum_s4 [2];
	logic signed [31:0] nvel_s4 [2];

	logic signed [48:0] tvel_w [2];
	logic signed [65:0] a_w    [2];
	logic signed [65:0] b_w    [2];
	logic signed [65:0] psum_w [2];

	assign acc_i[0] = p_in.acc_x;
	assign acc_i[1] = p_in.acc_y;
	assign vel_i[0] = p_in.vel_x;
	assign vel_i[1] = p_in.vel_y;
	assign cam_i[0] = cam_x;
	assign cam_i[1] = cam_y;
	assign dte_i    = $signed({1'b0, dt});
	assign dte_2    = $signed({1'b0, dt_s2});
	assign vel_2[0] = p_s2.vel_x;
	assign vel_2[1] = p_s2.vel_y;
	assign pos_3[0] = p_s3.pos_x;
	assign pos_3[1] = p_s3.pos_y;
	assign vel_3[0] = p_s3.vel_x;
	assign vel_3[1] = p_s3.vel_y;

	// stage 2: acceleration times dt, camera-relative velocity
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2  <= p_in;
			dt_s2 <= dt;
			for (int k = 0; k < 2; k++) begin
				ad_s2[k]   <= acc_i[k] * dte_i;
				diff_s2[k] <= vel_i[k] - cam_i[k];
			end
		end
	end

	// stage 3: second dt product, drift product, raw new velocity
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			tvel_w[k] = 49'(vel_2[k]) + (ad_s2[k] >>> 16);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= p_s2;
			for (int k = 0; k < 2; k++) begin
				add_s3[k]  <= ad_s2[k] * dte_2;
				bd_s3[k]   <= diff_s2[k] * dte_2;
				tvel_s3[k] <= tvel_w[k][32:0];
			end
		end
	end

	// stage 4: sum position terms, clamp velocity
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			a_w[k]    = add_s3[k] >>> 33;
			b_w[k]    = 66'(bd_s3[k] >>> 16);
			psum_w[k] = 66'(pos_3[k]) + b_w[k]
				+ ((p_s3.action == ACT_EXPLOSION) ? a_w[k] : 66'sd0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s4 <= p_s3;
			for (int k = 0; k < 2; k++) begin
				psum_s4[k] <= psum_w[k][35:0];
				nvel_s4[k] <= (p_s3.action == ACT_EXPLOSION) ?
					sat32(66'(tvel_s3[k])) : vel_3[k];
			end
		end
	end

	// stage 5: clamp position; for explosions acceleration follows minus velocity
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			nacc_w[k] = (nvel_s4[k] == 32'sh80000000) ? 32'sh7fffffff : -nvel_s4[k];
		end
	end

	always_comb begin
		p5_w       = p_s4;
		p5_w.pos_x = sat32(66'(psum_s4[0]));
		p5_w.pos_y = sat32(66'(psum_s4[1]));
		p5_w.vel_x = nvel_s4[0];
		p5_w.vel_y = nvel_s4[1];
		if (p_s4.action == ACT_EXPLOSION) begin
			p5_w.acc_x = nacc_w[0];
			p5_w.acc_y = nacc_w[1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s5 <= p5_w;
		end
	end

	assign p_out = p_s5;

endmodule

// ----- rtl/pus_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle update step: life ratio divider
// Restoring division, one quotient bit per stage, giving life / lifetime
// as Q1.15 clamped to [0, 1].
// ----------------------------------------------------------------------------
module pus_div (
	input  logic               clk,
	input  logic               en,
	input  logic signed [23:0] life,
	input  logic [22:0]        lifetime,
	output logic [15:0]        ratio
);
	import pus_pkg::*;

	logic                 life_zero;
	logic                 life_one;
	logic [22:0]          rem_q  [0:DIV_STEPS];
	logic [22:0]          dvs_q  [0:DIV_STEPS];
	logic [DIV_STEPS-1:0] quo_q  [0:DIV_STEPS];
	logic                 zero_q [0:DIV_STEPS];
	logic                 one_q  [0:DIV_STEPS];
	logic [22:0]          nrem   [1:DIV_STEPS];
	logic [DIV_STEPS-1:0] nquo   [1:DIV_STEPS];

	// flag the clamped cases up front
	assign life_zero = life[23] || (life == 24'sd0);
	assign life_one  = !life_zero && ((lifetime == 23'd0) || (life[22:0] >= lifetime));

	// one shift-and-subtract per stage
	always_comb begin
		logic [23:0] trial;
		logic [23:0] diff;
		for (int k = 1; k <= DIV_STEPS; k++) begin
			trial = {rem_q[k-1], 1'b0};
			diff  = trial - {1'b0, dvs_q[k-1]};
			if (trial >= {1'b0, dvs_q[k-1]}) begin
				nrem[k] = diff[22:0];
				nquo[k] = {quo_q[k-1][DIV_STEPS-2:0], 1'b1};
			end else begin
				nrem[k] = trial[22:0];
				nquo[k] = {quo_q[k-1][DIV_STEPS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= life[22:0];
			dvs_q[0]  <= lifetime;
			quo_q[0]  <= '0;
			zero_q[0] <= life_zero;
			one_q[0]  <= life_one;
			for (int k = 1; k <= DIV_STEPS; k++) begin
				rem_q[k]  <= nrem[k];
				dvs_q[k]  <= dvs_q[k-1];
				quo_q[k]  <= nquo[k];
				zero_q[k] <= zero_q[k-1];
				one_q[k]  <= one_q[k-1];
			end
		end
	end

	assign ratio = one_q[DIV_STEPS]  ? Q15_ONE :
	               zero_q[DIV_STEPS] ? 16'd0   : {1'b0, quo_q[DIV_STEPS]};

endmodule

// ----- rtl/pus_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle update step: square root
// Digit-by-digit integer square root of ratio * 2^15, one result bit per
// stage; the ratio rides along for the alpha channel.
// ----------------------------------------------------------------------------
module pus_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] ratio,
	output logic [15:0] root,
	output logic [15:0] ratio_out
);
	import pus_pkg::*;

	logic [31:0] x_q   [0:SQRT_STEPS-1];
	logic [31:0] res_q [0:SQRT_STEPS-1];
	logic [15:0] rat_q [0:SQRT_STEPS-1];
	logic [31:0] px    [0:SQRT_STEPS-1];
	logic [31:0] pres  [0:SQRT_STEPS-1];
	logic [15:0] prat  [0:SQRT_STEPS-1];
	logic [31:0] nx    [0:SQRT_STEPS-1];
	logic [31:0] nres  [0:SQRT_STEPS-1];

	// one iteration per stage, trial bit fixed by the stage
	always_comb begin
		logic [31:0] bitv;
		logic [31:0] trial;
		px[0]   = {1'b0, ratio, 15'b0};
		pres[0] = '0;
		prat[0] = ratio;
		for (int k = 1; k < SQRT_STEPS; k++) begin
			px[k]   = x_q[k-1];
			pres[k] = res_q[k-1];
			prat[k] = rat_q[k-1];
		end
		for (int k = 0; k < SQRT_STEPS; k++) begin
			bitv  = 32'd1 << (30 - 2 * k);
			trial = pres[k] + bitv;
			if (px[k] >= trial) begin
				nx[k]   = px[k] - trial;
				nres[k] = (pres[k] >> 1) + bitv;
			end else begin
				nx[k]   = px[k];
				nres[k] = pres[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQRT_STEPS; k++) begin
				x_q[k]   <= nx[k];
				res_q[k] <= nres[k];
				rat_q[k] <= prat[k];
			end
		end
	end

	assign root      = res_q[SQRT_STEPS-1][15:0];
	assign ratio_out = rat_q[SQRT_STEPS-1];

endmodule

// ----- rtl/pus_color.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle update step: colour update
// Registered channel products, then blend toward the end colour (jet) or
// scale green and set alpha (explosion).
// ----------------------------------------------------------------------------
module pus_color (
	input  logic        clk,
	input  logic        en,
	input  logic        action,
	input  logic [63:0] col,
	input  logic [15:0] ratio,
	input  logic [15:0] root,
	output logic [63:0] new_col
);
	import pus_pkg::*;

	logic [15:0]        end_c  [4];
	logic [15:0]        end_s  [4];
	logic signed [16:0] dlt    [4];
	logic signed [16:0] root_e;
	logic signed [33:0] prod_s [4];
	logic               act_s;
	logic [63:0]        col_s;
	logic [15:0]        rat_s;
	logic [18:0]        blend_w [4];
	logic [15:0]        chan_w  [4];

	// end colour per channel; explosion scales green toward zero
	always_comb begin
		end_c[0] = (action == ACT_JET) ? END_R : 16'd0;
		end_c[1] = (action == ACT_JET) ? END_G : 16'd0;
		end_c[2] = 16'd0;
		end_c[3] = 16'd0;
		end_s[0] = (act_s == ACT_JET) ? END_R : 16'd0;
		end_s[1] = (act_s == ACT_JET) ? END_G : 16'd0;
		end_s[2] = 16'd0;
		end_s[3] = 16'd0;
		for (int i = 0; i < 4; i++) begin
			dlt[i] = $signed({1'b0, col[16*i +: 16]}) - $signed({1'b0, end_c[i]});
		end
	end

	assign root_e = $signed({1'b0, root});

	always_ff @(posedge clk) begin
		if (en) begin
			act_s <= action;
			col_s <= col;
			rat_s <= ratio;
			for (int i = 0; i < 4; i++) begin
				prod_s[i] <= root_e * dlt[i];
			end
		end
	end

	// shift down, add back end colour, keep 16 bits
	always_comb begin
		logic signed [33:0] sh;
		for (int i = 0; i < 4; i++) begin
			sh         = prod_s[i] >>> 15;
			blend_w[i] = sh[18:0] + {3'b0, end_s[i]};
			chan_w[i]  = blend_w[i][15:0];
		end
	end

	assign new_col = (act_s == ACT_JET) ?
		{chan_w[3], chan_w[2], chan_w[1], chan_w[0]} :
		{rat_s, col_s[47:32], chan_w[1], col_s[15:0]};

endmodule
